@@ sv/tcc_pkg.sv @@
// tcc_pkg: shared types, field widths, register map and level constants for the
// triggered capture controller. No dependencies; every other file refers to it.
`timescale 1ns / 1ps
`default_nettype none

package tcc_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int ADDR_W    = 20;
    localparam int COUNT_W   = 21;
    localparam int CFG20_W   = 20;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    // magnitude at or above which a sample counts as clipped (0.99 of full scale)
    localparam logic [SAMPLE_W-1:0] CLIP_MAG   = 24'd8304722;
    // block peak below this is silence (0.0001 of full scale)
    localparam logic [SAMPLE_W-1:0] SILENT_MAG = 24'd839;
    localparam logic [COUNT_W-1:0]  COUNT_MAX  = 21'h1FFFFF;

    localparam logic [CFG20_W-1:0]  TARGET_RST    = 20'd1047552;
    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 24'd0;
    localparam logic [CFG20_W-1:0]  GRACE_RST     = 20'd24000;
    localparam logic [CFG20_W-1:0]  SILENCE_RST   = 20'd9600;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_REC  = 2'd2,
        PH_DONE = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        REG_TARGET    = 3'd0,
        REG_THRESHOLD = 3'd1,
        REG_EARLY_EN  = 3'd2,
        REG_GRACE     = 3'd3,
        REG_SILENCE   = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [CFG20_W-1:0]  target_samples;
        logic [SAMPLE_W-1:0] trigger_threshold;
        logic                early_stop_enable;
        logic [CFG20_W-1:0]  grace_samples;
        logic [CFG20_W-1:0]  silence_limit;
    } cfg_t;

    typedef struct packed {
        logic                       action;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       block_end;
    } feed_word_t;

    typedef struct packed {
        logic                       store_enable;
        logic [ADDR_W-1:0]          store_address;
        logic signed [SAMPLE_W-1:0] store_sample;
        phase_t                     phase;
        logic                       overload;
        logic                       early_stopped;
        logic [COUNT_W-1:0]         recorded;
    } result_word_t;

endpackage

`default_nettype wire

@@ sv/tcc_feed_if.sv @@
// tcc_feed_if: valid/ready channel carrying arm commands and audio samples.
// Field widths come from tcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tcc_feed_if;
    logic                                valid;
    logic                                ready;
    logic                                action;
    logic signed [tcc_pkg::SAMPLE_W-1:0] sample;
    logic                                block_end;

    modport source (output valid, action, sample, block_end, input ready);
    modport sink   (input valid, action, sample, block_end, output ready);
endinterface

`default_nettype wire

@@ sv/tcc_result_if.sv @@
// tcc_result_if: valid/ready channel carrying one result word per accepted item.
// Field widths come from tcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tcc_result_if;
    logic                                valid;
    logic                                ready;
    logic                                store_enable;
    logic [tcc_pkg::ADDR_W-1:0]          store_address;
    logic signed [tcc_pkg::SAMPLE_W-1:0] store_sample;
    logic [1:0]                          phase;
    logic                                overload;
    logic                                early_stopped;
    logic [tcc_pkg::COUNT_W-1:0]         recorded;

    modport source (output valid, store_enable, store_address, store_sample, phase,
                    overload, early_stopped, recorded, input ready);
    modport sink   (input valid, store_enable, store_address, store_sample, phase,
                    overload, early_stopped, recorded, output ready);
endinterface

`default_nettype wire

@@ sv/triggered_capture_controller.sv @@
// triggered_capture_controller: top level; input word register, capture core, result
// register, apb settings. Depends on tcc_pkg, tcc_feed_if, tcc_result_if, tcc_cfg, tcc_core.
//
//   port     kind       role
//   feed     valid/rdy  sink: arm commands and samples with block-end mark
//   result   valid/rdy  source: one store/status word per accepted feed word
//   apb      psel/pen   settings, 5 registers at byte 4*i, pready tied high
//
// one word per cycle sustained while result is not stalled; a word is held in the input
// register, processed in a single pass by the core and then registered into the result
// register, from which result can take it.
// the core state advances when a word moves into the result register.
// a stalled result holds its register and backs up into the input register; feed
// stays ready while either stage can move.
// reset: phase idle, counters and flags clear, settings at their defaults.
`timescale 1ns / 1ps
`default_nettype none

module triggered_capture_controller #(
    parameter int BUF_DEPTH  = 1048576,
    parameter int CLIP_LIMIT = 700
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tcc_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [tcc_pkg::PDATA_W-1:0]  pwdata,
    output logic      [tcc_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready,
    tcc_feed_if.sink                          feed,
    tcc_result_if.source                      result
);

    tcc_pkg::cfg_t         cfg;
    tcc_pkg::feed_word_t   word_reg;
    tcc_pkg::result_word_t core_res;
    tcc_pkg::result_word_t res_reg;
    logic                  word_valid_reg;
    logic                  res_valid_reg;
    logic                  advance;
    logic                  feed_take;

    tcc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tcc_core #(
        .BUF_DEPTH  (BUF_DEPTH),
        .CLIP_LIMIT (CLIP_LIMIT)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .word  (word_reg),
        .cfg   (cfg),
        .res   (core_res)
    );

    // the word moves on when the result register is empty or being drained
    assign advance    = word_valid_reg && (!res_valid_reg || result.ready);
    assign feed.ready = !word_valid_reg || advance;
    assign feed_take  = feed.valid && feed.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (feed.ready)
                word_valid_reg <= feed.valid;
            if (advance)
                res_valid_reg <= 1'b1;
            else if (result.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (feed_take)
        begin
            word_reg.action    <= feed.action;
            word_reg.sample    <= feed.sample;
            word_reg.block_end <= feed.block_end;
        end
        if (advance)
            res_reg <= core_res;
    end

    assign result.valid         = res_valid_reg;
    assign result.store_enable  = res_reg.store_enable;
    assign result.store_address = res_reg.store_address;
    assign result.store_sample  = res_reg.store_sample;
    assign result.phase         = res_reg.phase;
    assign result.overload      = res_reg.overload;
    assign result.early_stopped = res_reg.early_stopped;
    assign result.recorded      = res_reg.recorded;

endmodule

`default_nettype wire

@@ sv/tcc_cfg.sv @@
// tcc_cfg: apb register file for the capture settings (target, trigger threshold,
// early stop enable, grace and silence limits). Depends on tcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcc_cfg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tcc_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [tcc_pkg::PDATA_W-1:0]  pwdata,
    output logic      [tcc_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready,
    output tcc_pkg::cfg_t                     cfg
);

    tcc_pkg::cfg_t    cfg_reg;
    tcc_pkg::cfg_t    cfg_next;
    tcc_pkg::cfg_idx_t idx;
    logic             wr_en;

    assign idx    = tcc_pkg::cfg_idx_t'(paddr[tcc_pkg::PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                tcc_pkg::REG_TARGET:
                    cfg_next.target_samples = pwdata[tcc_pkg::CFG20_W-1:0];
                tcc_pkg::REG_THRESHOLD:
                    cfg_next.trigger_threshold = pwdata[tcc_pkg::SAMPLE_W-1:0];
                tcc_pkg::REG_EARLY_EN:
                    cfg_next.early_stop_enable = pwdata[0];
                tcc_pkg::REG_GRACE:
                    cfg_next.grace_samples = pwdata[tcc_pkg::CFG20_W-1:0];
                tcc_pkg::REG_SILENCE:
                    cfg_next.silence_limit = pwdata[tcc_pkg::CFG20_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            tcc_pkg::REG_TARGET:    prdata = 32'(cfg_reg.target_samples);
            tcc_pkg::REG_THRESHOLD: prdata = 32'(cfg_reg.trigger_threshold);
            tcc_pkg::REG_EARLY_EN:  prdata = 32'(cfg_reg.early_stop_enable);
            tcc_pkg::REG_GRACE:     prdata = 32'(cfg_reg.grace_samples);
            tcc_pkg::REG_SILENCE:   prdata = 32'(cfg_reg.silence_limit);
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_samples    <= tcc_pkg::TARGET_RST;
            cfg_reg.trigger_threshold <= tcc_pkg::THRESHOLD_RST;
            cfg_reg.early_stop_enable <= 1'b0;
            cfg_reg.grace_samples     <= tcc_pkg::GRACE_RST;
            cfg_reg.silence_limit     <= tcc_pkg::SILENCE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/tcc_core.sv @@
// tcc_core: capture state (phase, clip guard, counters, write pointer, block peak)
// and the per-word update, done in one pass. Depends on tcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcc_core #(
    parameter int BUF_DEPTH  = 1048576,
    parameter int CLIP_LIMIT = 700
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  fire,
    input  wire tcc_pkg::feed_word_t   word,
    input  wire tcc_pkg::cfg_t         cfg,
    output tcc_pkg::result_word_t      res
);

    localparam int PTR_W  = $clog2(BUF_DEPTH);
    localparam int CLIP_W = $clog2(CLIP_LIMIT + 2);
    localparam int TGT_W  = (PTR_W > tcc_pkg::COUNT_W) ? PTR_W : tcc_pkg::COUNT_W;
    localparam int AW     = tcc_pkg::ADDR_W;
    localparam int CW     = tcc_pkg::COUNT_W;
    localparam int SW     = tcc_pkg::SAMPLE_W;
    localparam logic [TGT_W-1:0]  TGT_CAP  = TGT_W'(BUF_DEPTH - 1024);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(BUF_DEPTH - 1);
    localparam logic [CLIP_W-1:0] CLIP_LIM = CLIP_W'(CLIP_LIMIT);

    tcc_pkg::phase_t   phase_reg, phase_next, phase_trig;
    logic [CLIP_W-1:0] clip_reg, clip_next, clip_inc;
    logic              overload_reg, overload_next;
    logic              early_reg, early_next;
    logic [CW-1:0]     recorded_reg, recorded_next, recorded_inc;
    logic [PTR_W-1:0]  ptr_reg, ptr_next, ptr_inc;
    logic [CW-1:0]     silence_reg, silence_next;
    logic [SW-1:0]     peak_reg, peak_next, peak_upd;
    logic [CW-1:0]     bsamp_reg, bsamp_next, bsamp_upd;

    logic [SW-1:0]     mag;
    logic              is_clip, sample_go, abort, recording, store_now;
    logic [TGT_W-1:0]  tgt, tgt_cfg;
    logic [CW:0]       sil_wide;
    logic [CW-1:0]     sil_sum;
    logic              chk, silent, stop;

    // magnitude; full-scale negative gives 2^23, still fits unsigned
    assign mag      = word.sample[SW-1] ? (~word.sample + 1'b1) : word.sample;
    assign is_clip  = mag >= tcc_pkg::CLIP_MAG;
    assign clip_inc = clip_reg + 1'b1;

    assign sample_go = !word.action && !overload_reg;
    assign abort     = sample_go && is_clip && (clip_inc > CLIP_LIM);

    assign phase_trig = (phase_reg == tcc_pkg::PH_WAIT && mag >= cfg.trigger_threshold)
                        ? tcc_pkg::PH_REC : phase_reg;

    assign tgt_cfg   = TGT_W'(cfg.target_samples);
    assign tgt       = (tgt_cfg < TGT_CAP) ? tgt_cfg : TGT_CAP;
    assign recording = sample_go && !abort && (phase_trig == tcc_pkg::PH_REC);
    assign store_now = recording && (TGT_W'(recorded_reg) < tgt);

    assign recorded_inc = recorded_reg + CW'(store_now);
    assign ptr_inc      = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;
    assign peak_upd     = (mag > peak_reg) ? mag : peak_reg;
    assign bsamp_upd    = (bsamp_reg == tcc_pkg::COUNT_MAX) ? bsamp_reg : bsamp_reg + 1'b1;

    assign sil_wide = {1'b0, silence_reg} + {1'b0, bsamp_upd};
    assign sil_sum  = sil_wide[CW] ? tcc_pkg::COUNT_MAX : sil_wide[CW-1:0];

    assign chk    = word.block_end && cfg.early_stop_enable
                    && (recorded_inc > CW'(cfg.grace_samples));
    assign silent = peak_upd < tcc_pkg::SILENT_MAG;
    assign stop   = chk && silent && (sil_sum > CW'(cfg.silence_limit));

    // next state
    always_comb
    begin
        phase_next    = phase_reg;
        clip_next     = clip_reg;
        overload_next = overload_reg;
        early_next    = early_reg;
        recorded_next = recorded_reg;
        ptr_next      = ptr_reg;
        silence_next  = silence_reg;
        peak_next     = peak_reg;
        bsamp_next    = bsamp_reg;
        if (word.action)
        begin
            clip_next     = '0;
            overload_next = 1'b0;
            early_next    = 1'b0;
            recorded_next = '0;
            ptr_next      = '0;
            silence_next  = '0;
            peak_next     = '0;
            bsamp_next    = '0;
            phase_next    = (cfg.trigger_threshold == '0) ? tcc_pkg::PH_REC
                                                          : tcc_pkg::PH_WAIT;
        end
        else if (sample_go)
        begin
            if (is_clip)
                clip_next = clip_inc;
            else if (clip_reg != '0)
                clip_next = clip_reg - 1'b1;

            if (abort)
            begin
                overload_next = 1'b1;
                phase_next    = tcc_pkg::PH_DONE;
                peak_next     = '0;
                bsamp_next    = '0;
            end
            else if (recording)
            begin
                phase_next    = tcc_pkg::PH_REC;
                recorded_next = recorded_inc;
                if (store_now)
                    ptr_next = ptr_inc;
                if (word.block_end)
                begin
                    peak_next  = '0;
                    bsamp_next = '0;
                    if (chk)
                    begin
                        if (!silent)
                            silence_next = '0;
                        else if (!stop)
                            silence_next = sil_sum;
                    end
                    if (stop)
                    begin
                        early_next = 1'b1;
                        phase_next = tcc_pkg::PH_DONE;
                    end
                    else if (TGT_W'(recorded_inc) >= tgt)
                        phase_next = tcc_pkg::PH_DONE;
                end
                else
                begin
                    peak_next  = peak_upd;
                    bsamp_next = bsamp_upd;
                end
            end
            else
            begin
                phase_next = phase_trig;
                peak_next  = '0;
                bsamp_next = '0;
            end
        end
    end

    // result word
    always_comb
    begin
        res.store_enable  = store_now;
        res.store_address = word.action ? '0 : AW'(ptr_reg);
        res.store_sample  = store_now ? word.sample : '0;
        res.phase         = phase_next;
        res.overload      = overload_next;
        res.early_stopped = early_next;
        res.recorded      = recorded_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= tcc_pkg::PH_IDLE;
            clip_reg     <= '0;
            overload_reg <= 1'b0;
            early_reg    <= 1'b0;
            recorded_reg <= '0;
            ptr_reg      <= '0;
            silence_reg  <= '0;
            peak_reg     <= '0;
            bsamp_reg    <= '0;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            clip_reg     <= clip_next;
            overload_reg <= overload_next;
            early_reg    <= early_next;
            recorded_reg <= recorded_next;
            ptr_reg      <= ptr_next;
            silence_reg  <= silence_next;
            peak_reg     <= peak_next;
            bsamp_reg    <= bsamp_next;
        end
    end

`ifndef ASSERT_OFF
    a_arm_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && word.action |=> recorded_reg == '0 && ptr_reg == '0 && clip_reg == '0)
        else $error("arm did not clear counters");

    a_overload_done: assert property (@(posedge clk) disable iff (!rst_n)
        overload_reg |-> phase_reg == tcc_pkg::PH_DONE)
        else $error("overload latched outside finished phase");

    a_overload_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        fire && overload_reg && !word.action |=> $stable(recorded_reg) && $stable(ptr_reg))
        else $error("state moved while overloaded");

    a_block_clear: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != tcc_pkg::PH_REC |-> peak_reg == '0 && bsamp_reg == '0)
        else $error("block accumulators set outside recording");
`endif

endmodule

`default_nettype wire
